// ===== src/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and defaults for the first-fit fragment allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	// default table depth and address width
	localparam int MAX_RANGES_DEF = 64;
	localparam int ADDR_BITS_DEF  = 16;

	// request modes
	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NO_FIT = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_BAD    = 2'd3
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_MOVE     = 6'b000100,
		ST_SPLIT_HI = 6'b001000,
		ST_SPLIT_LO = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== src/first_fit_fragment_allocator.sv =====
// add, clear, a remove of the last entry and a request rejected at decode go from idle
//   straight to done, which loads the response register once it is free
// find: scans the entries in order from index 0 until one fits or the table ends, and a
//   split shifts the entries above the hit up by one to open a slot; remove with gap close shifts them down
// one request at a time: req_ready is high only while idle, and the range memory has a
//   single read and single write port; reset: arst_n empties the table at once, memory contents are not cleared
// ----------------------------------------------------------------------------
// first_fit_fragment_allocator
// ordered table of free address ranges with add, first-fit find with split,
// remove with gap close, and clear; the table lives in one synchronous memory
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_fragment_allocator
	import ffa_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] range_start,
	input  logic [15:0] range_end,
	input  logic [16:0] request_size,
	input  logic [5:0]  entry_index,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [5:0]  found_index,
	output logic [15:0] found_start,
	output logic [15:0] found_end,
	output logic [6:0]  range_count
);

	// index, count, span and entry widths
	localparam int IW  = $clog2(MAX_RANGES);
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int CW1 = CW + 1;
	localparam int SW  = (ADDR_BITS + 1 > 17) ? ADDR_BITS + 1 : 17;
	localparam int PW  = ((CW > 6) ? CW : 6) + 1;
	localparam int EW  = 2 * ADDR_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

	// range memory: start in the upper half of a word, end in the lower half
	logic [EW-1:0] entry_mem_q [MAX_RANGES];
	logic [EW-1:0] mem_rdata_q;
	logic [IW-1:0] mem_raddr;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;

	// sequencer
	state_t        state_q;
	logic [CW-1:0] count_q;

	// scan pipeline: read issued at scan_q, checked in the next cycle
	logic [CW-1:0] scan_q;
	logic          chk_v_s1;
	logic [CW-1:0] chk_idx_s1;
	logic [16:0]   want_q;

	// fitting entry and its split halves
	logic [CW-1:0]        hit_idx_q;
	logic [ADDR_BITS-1:0] hit_start_q;
	logic [ADDR_BITS-1:0] hit_end_q;
	logic [ADDR_BITS-1:0] split_start_q;
	logic [ADDR_BITS-1:0] split_end_q;

	// move engine: read at mv_src_q, write the data in the next cycle at mv_dst_s1
	logic [IW-1:0] mv_src_q;
	logic [IW-1:0] mv_end_q;
	logic          mv_up_q;
	logic          mv_issue_q;
	logic          mv_v_s1;
	logic [IW-1:0] mv_dst_s1;

	// pending result
	status_t              res_status_q;
	logic [CW-1:0]        res_index_q;
	logic [ADDR_BITS-1:0] res_start_q;
	logic [ADDR_BITS-1:0] res_end_q;

	// response register
	logic        rsp_valid_q;
	status_t     status_q;
	logic [5:0]  found_index_q;
	logic [15:0] found_start_q;
	logic [15:0] found_end_q;
	logic [6:0]  range_count_q;

	// request decode, addresses masked to the table width
	logic [ADDR_BITS-1:0] in_start;
	logic [ADDR_BITS-1:0] in_end;
	logic [PW-1:0]        pos_w;
	logic [PW-1:0]        cnt_w;

	assign in_start = ADDR_BITS'(range_start);
	assign in_end   = ADDR_BITS'(range_end);
	assign pos_w    = PW'(entry_index);
	assign cnt_w    = PW'(count_q);

	// fit check on the entry read back from memory
	logic [ADDR_BITS-1:0] rd_start;
	logic [ADDR_BITS-1:0] rd_end;
	logic [SW-1:0]        span;
	logic [SW-1:0]        cut;
	logic                 fits;
	logic                 exact;

	assign rd_start = mem_rdata_q[EW-1:ADDR_BITS];
	assign rd_end   = mem_rdata_q[ADDR_BITS-1:0];
	assign span     = SW'(rd_end) - SW'(rd_start) + SW'(1);
	assign cut      = SW'(rd_start) + SW'(want_q);
	assign fits     = (rd_end >= rd_start) && (span >= SW'(want_q));
	assign exact    = (span == SW'(want_q));

	assign req_ready = (state_q == ST_IDLE);

	// read address: the scan pointer while searching, the move source while shifting
	always_comb begin
		case (state_q)
			ST_SCAN: mem_raddr = IW'(scan_q);
			ST_MOVE: mem_raddr = mv_src_q;
			default: mem_raddr = '0;
		endcase
	end

	// write port: append, shifted entry, or the two halves of a split
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && (mode_t'(mode) == MODE_ADD) && (in_end >= in_start)
				    && (count_q < MAX_CNT)) begin
					mem_we    = 1'b1;
					mem_waddr = IW'(count_q);
					mem_wdata = {in_start, in_end};
				end
			end
			ST_MOVE: begin
				mem_we    = mv_v_s1;
				mem_waddr = mv_dst_s1;
				mem_wdata = mem_rdata_q;
			end
			ST_SPLIT_HI: begin
				// remainder goes right after the fitting entry
				mem_we    = 1'b1;
				mem_waddr = IW'(hit_idx_q + CW'(1));
				mem_wdata = {split_start_q, hit_end_q};
			end
			ST_SPLIT_LO: begin
				// fitting entry shrinks to the granted part
				mem_we    = 1'b1;
				mem_waddr = IW'(hit_idx_q);
				mem_wdata = {hit_start_q, split_end_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= entry_mem_q[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			scan_q        <= '0;
			chk_v_s1      <= 1'b0;
			chk_idx_s1    <= '0;
			want_q        <= '0;
			hit_idx_q     <= '0;
			hit_start_q   <= '0;
			hit_end_q     <= '0;
			split_start_q <= '0;
			split_end_q   <= '0;
			mv_src_q      <= '0;
			mv_end_q      <= '0;
			mv_up_q       <= 1'b0;
			mv_issue_q    <= 1'b0;
			mv_v_s1       <= 1'b0;
			mv_dst_s1     <= '0;
			res_status_q  <= STAT_OK;
			res_index_q   <= '0;
			res_start_q   <= '0;
			res_end_q     <= '0;
			rsp_valid_q   <= 1'b0;
			status_q      <= STAT_OK;
			found_index_q <= '0;
			found_start_q <= '0;
			found_end_q   <= '0;
			range_count_q <= '0;
		end else begin
			// scan check and move write strobes follow the read in the next cycle
			chk_v_s1 <= (state_q == ST_SCAN) && (scan_q < count_q);
			mv_v_s1  <= (state_q == ST_MOVE) && mv_issue_q;

			// response register loads from done and drops once taken
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						// found fields stay zero unless a find succeeds
						res_index_q <= '0;
						res_start_q <= '0;
						res_end_q   <= '0;
						state_q     <= ST_DONE;
						case (mode_t'(mode))
							MODE_ADD: begin
								if (in_end < in_start) begin
									res_status_q <= STAT_BAD;
								end else if (count_q >= MAX_CNT) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_status_q <= STAT_OK;
									count_q      <= count_q + CW'(1);
								end
							end
							MODE_FIND: begin
								want_q <= request_size;
								if (request_size == 17'd0) begin
									res_status_q <= STAT_BAD;
								end else if (count_q == '0) begin
									res_status_q <= STAT_NO_FIT;
								end else begin
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
							MODE_REMOVE: begin
								if (pos_w >= cnt_w) begin
									res_status_q <= STAT_BAD;
								end else begin
									res_status_q <= STAT_OK;
									if (pos_w + PW'(1) == cnt_w) begin
										// last entry: nothing to close up
										count_q <= count_q - CW'(1);
									end else begin
										mv_src_q   <= IW'(entry_index) + IW'(1);
										mv_end_q   <= IW'(count_q - CW'(1));
										mv_up_q    <= 1'b0;
										mv_issue_q <= 1'b1;
										state_q    <= ST_MOVE;
									end
								end
							end
							default: begin
								res_status_q <= STAT_OK;
								count_q      <= '0;
							end
						endcase
					end
				end

				ST_SCAN: begin
					// issue the next read while checking the previous one
					if (scan_q < count_q) begin
						chk_idx_s1 <= scan_q;
						scan_q     <= scan_q + CW'(1);
					end
					if (chk_v_s1) begin
						if (fits) begin
							hit_idx_q     <= chk_idx_s1;
							hit_start_q   <= rd_start;
							hit_end_q     <= rd_end;
							split_start_q <= ADDR_BITS'(cut);
							split_end_q   <= ADDR_BITS'(cut - SW'(1));
							if (exact) begin
								res_status_q <= STAT_OK;
								res_index_q  <= chk_idx_s1;
								res_start_q  <= rd_start;
								res_end_q    <= rd_end;
								state_q      <= ST_DONE;
							end else if (count_q >= MAX_CNT) begin
								res_status_q <= STAT_FULL;
								state_q      <= ST_DONE;
							end else if (chk_idx_s1 + CW'(1) == count_q) begin
								// fitting entry is the tail, no shift needed
								state_q <= ST_SPLIT_HI;
							end else begin
								// shift entries above the hit up by one, top first
								mv_src_q   <= IW'(count_q - CW'(1));
								mv_end_q   <= IW'(chk_idx_s1 + CW'(1));
								mv_up_q    <= 1'b1;
								mv_issue_q <= 1'b1;
								state_q    <= ST_MOVE;
							end
						end else if (chk_idx_s1 + CW'(1) == count_q) begin
							res_status_q <= STAT_NO_FIT;
							state_q      <= ST_DONE;
						end
					end
				end

				ST_MOVE: begin
					if (mv_issue_q) begin
						mv_dst_s1 <= mv_up_q ? mv_src_q + IW'(1) : mv_src_q - IW'(1);
						if (mv_src_q == mv_end_q) begin
							mv_issue_q <= 1'b0;
						end else begin
							mv_src_q <= mv_up_q ? mv_src_q - IW'(1) : mv_src_q + IW'(1);
						end
					end else begin
						// last shifted entry is written in this cycle
						if (mv_up_q) begin
							state_q <= ST_SPLIT_HI;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= ST_DONE;
						end
					end
				end

				ST_SPLIT_HI: begin
					state_q <= ST_SPLIT_LO;
				end

				ST_SPLIT_LO: begin
					count_q      <= count_q + CW'(1);
					res_status_q <= STAT_OK;
					res_index_q  <= hit_idx_q;
					res_start_q  <= hit_start_q;
					res_end_q    <= split_end_q;
					state_q      <= ST_DONE;
				end

				ST_DONE: begin
					// hand over once the response register is free
					if (!rsp_valid_q || rsp_ready) begin
						status_q      <= res_status_q;
						found_index_q <= 6'(res_index_q);
						found_start_q <= 16'(res_start_q);
						found_end_q   <= 16'(res_end_q);
						range_count_q <= 7'(count_q);
						state_q       <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign found_start = found_start_q;
	assign found_end   = found_end_q;
	assign range_count = range_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count beyond table depth");

	a_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW1'(mem_waddr) <= CW1'(count_q)))
		else $error("memory write beyond the used part of the table");

	a_move_trail: assert property (@(posedge clk) disable iff (!arst_n)
		mv_v_s1 |-> (state_q == ST_MOVE))
		else $error("shifted entry left without its write");

	a_scan_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_v_s1) |-> (chk_idx_s1 < count_q))
		else $error("scan checks an entry beyond the count");

	a_full_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == STAT_FULL) |-> (range_count_q == 7'(MAX_RANGES)))
		else $error("table full reported below depth");

	a_idle_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !mv_issue_q)
		else $error("move still issuing while idle");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_first_fit_fragment_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_fragment_allocator
// self-checking bench for the first-fit free range table: a short directed
// sequence, then random episodes that fill, split, trim and clear the table
// under random sender gaps and receiver stalls, with every reply checked
// against a local model of the range table
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_fragment_allocator;
	import ffa_pkg::*;

	localparam int DEPTH        = MAX_RANGES_DEF;
	localparam int RANDOM_ITEMS = 420;
	localparam int QUIET_ITEMS  = 80;
	// worst reply: scan to the last entry, then open a slot at the tail
	localparam int DRAIN_CYCLES = 2 * DEPTH + 40;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  index;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [6:0]  count;
	} reply_t;

	// local copy of the range table, plus the replies it has promised
	class free_range_tracker;
		logic [15:0] lo_tab [DEPTH];
		logic [15:0] hi_tab [DEPTH];
		int used;
		reply_t owed_replies [$];
		int errors;
		int replies_seen;

		task flag_mismatch(string what);
			errors++;
			$display("mismatch at reply %0d: %s", replies_seen, what);
		endtask

		function int pending();
			return owed_replies.size();
		endfunction

		function int unsigned span_at(int j);
			return 32'(hi_tab[j]) - 32'(lo_tab[j]) + 1;
		endfunction

		// apply one accepted transaction and queue the reply it must produce
		function void note_request(mode_t op, logic [15:0] s, logic [15:0] e,
				logic [16:0] want, logic [5:0] pos);
			reply_t r;
			int unsigned span;
			bit placed;
			r.status = STAT_OK;
			r.index  = '0;
			r.lo     = '0;
			r.hi     = '0;
			placed   = 1'b0;
			case (op)
			MODE_ADD: begin
				if (e < s) begin
					r.status = STAT_BAD;
				end else if (used >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					lo_tab[used] = s;
					hi_tab[used] = e;
					used++;
				end
			end
			MODE_FIND: begin
				if (want == '0) begin
					r.status = STAT_BAD;
				end else begin
					r.status = STAT_NO_FIT;
					for (int i = 0; i < used && !placed; i++) begin
						span = span_at(i);
						if (hi_tab[i] >= lo_tab[i] && span >= 32'(want)) begin
							placed = 1'b1;
							if (span > 32'(want) && used >= DEPTH) begin
								r.status = STAT_FULL;
							end else begin
								if (span > 32'(want)) begin
									for (int k = used; k > i + 1; k--) begin
										lo_tab[k] = lo_tab[k - 1];
										hi_tab[k] = hi_tab[k - 1];
									end
									lo_tab[i + 1] = lo_tab[i] + want[15:0];
									hi_tab[i + 1] = hi_tab[i];
									hi_tab[i]     = lo_tab[i] + want[15:0] - 16'd1;
									used++;
								end
								r.status = STAT_OK;
								r.index  = 6'(i);
								r.lo     = lo_tab[i];
								r.hi     = hi_tab[i];
							end
						end
					end
				end
			end
			MODE_REMOVE: begin
				if (int'(pos) >= used) begin
					r.status = STAT_BAD;
				end else begin
					for (int k = int'(pos); k + 1 < used; k++) begin
						lo_tab[k] = lo_tab[k + 1];
						hi_tab[k] = hi_tab[k + 1];
					end
					used--;
				end
			end
			default: begin
				used = 0;
			end
			endcase
			r.count = 7'(used);
			owed_replies.push_back(r);
		endfunction

		task check_reply(logic [1:0] st, logic [5:0] idx, logic [15:0] lo,
				logic [15:0] hi, logic [6:0] cnt);
			reply_t w;
			replies_seen++;
			if (owed_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with nothing outstanding, status %0d", st));
				return;
			end
			w = owed_replies.pop_front();
			if (st !== w.status)
				flag_mismatch($sformatf("status %0d, want %0d", st, w.status));
			if (idx !== w.index)
				flag_mismatch($sformatf("found_index %0d, want %0d", idx, w.index));
			if (lo !== w.lo)
				flag_mismatch($sformatf("found_start %h, want %h", lo, w.lo));
			if (hi !== w.hi)
				flag_mismatch($sformatf("found_end %h, want %h", hi, w.hi));
			if (cnt !== w.count)
				flag_mismatch($sformatf("range_count %0d, want %0d", cnt, w.count));
		endtask
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic        req_ready;
	logic [1:0]  mode         = MODE_ADD;
	logic [15:0] range_start  = '0;
	logic [15:0] range_end    = '0;
	logic [16:0] request_size = '0;
	logic [5:0]  entry_index  = '0;
	logic        rsp_valid;
	logic        rsp_ready    = 1'b0;
	logic [1:0]  status;
	logic [5:0]  found_index;
	logic [15:0] found_start;
	logic [15:0] found_end;
	logic [6:0]  range_count;

	free_range_tracker tracker = new();

	int items_sent = 0;
	int quiet_from = 32'h7fffffff;
	bit quiet      = 1'b0;
	int stall_left = 0;

	first_fit_fragment_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.mode         (mode),
		.range_start  (range_start),
		.range_end    (range_end),
		.request_size (request_size),
		.entry_index  (entry_index),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.found_index  (found_index),
		.found_start  (found_start),
		.found_end    (found_end),
		.range_count  (range_count)
	);

	always #4 clk = ~clk;

	// receiver: check every reply transaction, stall in random bursts
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_ready)
			tracker.check_reply(status, found_index, found_start, found_end, range_count);
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			stall_left = $urandom_range(1, 8) - 1;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// one request transaction; valid stays up across back-to-back requests
	task automatic send_req(mode_t op, logic [15:0] s, logic [15:0] e,
			logic [16:0] want, logic [5:0] pos);
		quiet = (items_sent >= quiet_from);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid    <= 1'b1;
		mode         <= op;
		range_start  <= s;
		range_end    <= e;
		request_size <= want;
		entry_index  <= pos;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		tracker.note_request(op, s, e, want, pos);
		items_sent++;
	endtask

	// drop valid and wait for every outstanding reply
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic send_clear();
		send_req(MODE_CLEAR, 16'($urandom), 16'($urandom), 17'($urandom), 6'($urandom));
	endtask

	// mostly well-formed ranges of assorted lengths, some inverted
	task automatic add_random();
		logic [15:0] s;
		logic [15:0] e;
		int unsigned len;
		s = 16'($urandom);
		case ($urandom_range(0, 7))
		0: len = $urandom_range(0, 3);
		1, 2, 3: len = $urandom_range(0, 255);
		4: len = $urandom_range(0, 65535 - 32'(s));
		5: begin
			s   = 16'($urandom_range(0, 3));
			len = 65535 - 32'(s);
		end
		default: len = $urandom_range(0, 4095);
		endcase
		e = (32'(s) + len > 65535) ? 16'hffff : 16'(32'(s) + len);
		// inverted range
		if ($urandom_range(0, 7) == 0) begin
			s = 16'($urandom_range(1, 65535));
			e = 16'($urandom_range(0, 32'(s) - 1));
		end
		send_req(MODE_ADD, s, e, 17'($urandom), 6'($urandom));
	endtask

	// sizes aimed at live entries so the scan, split and exact-fit paths all run
	task automatic find_random();
		logic [16:0] want;
		int j;
		j = (tracker.used > 0) ? $urandom_range(0, tracker.used - 1) : 0;
		case ($urandom_range(0, 9))
		0, 1, 2: want = (tracker.used > 0) ? 17'(tracker.span_at(j)) : 17'd1;
		3, 4: want = (tracker.used > 0) ? 17'($urandom_range(1, tracker.span_at(j))) : 17'd1;
		5, 6: want = 17'($urandom_range(1, 300));
		7: want = 17'($urandom);
		8: want = $urandom_range(0, 1) ? 17'h10000 : 17'h1ffff;
		default: want = '0;
		endcase
		send_req(MODE_FIND, 16'($urandom), 16'($urandom), want, 6'($urandom));
	endtask

	task automatic remove_random();
		logic [5:0] pos;
		if (tracker.used > 0 && $urandom_range(0, 4) != 0)
			pos = 6'($urandom_range(0, tracker.used - 1));
		else
			pos = 6'($urandom);
		send_req(MODE_REMOVE, 16'($urandom), 16'($urandom), 17'($urandom), pos);
	endtask

	// stimulus
	initial begin
		int random_target;
		int episode;
		logic [15:0] s;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, field extremes, exact and split fits, bad requests
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'd1,     6'd0);
		send_req(MODE_REMOVE, 16'h0000, 16'h0000, 17'd0,     6'd0);
		send_req(MODE_ADD,    16'h0000, 16'h0000, 17'h1ffff, 6'h3f);
		send_req(MODE_ADD,    16'hffff, 16'hffff, 17'd0,     6'd0);
		send_req(MODE_ADD,    16'h8000, 16'h7fff, 17'd5,     6'd1);
		send_req(MODE_ADD,    16'h0000, 16'hffff, 17'd0,     6'd0);
		send_req(MODE_FIND,   16'hffff, 16'hffff, 17'd0,     6'h3f);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'h1ffff, 6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'h10000, 6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'd1,     6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'd2,     6'd0);
		send_req(MODE_ADD,    16'h1000, 16'h10ff, 17'd0,     6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'd16,    6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'h0ff00, 6'd0);
		send_req(MODE_REMOVE, 16'h0000, 16'h0000, 17'd0,     6'(tracker.used - 1));
		send_req(MODE_REMOVE, 16'h0000, 16'h0000, 17'd0,     6'd0);
		send_req(MODE_REMOVE, 16'h0000, 16'h0000, 17'd0,     6'h3f);
		send_req(MODE_CLEAR,  16'hffff, 16'hffff, 17'h1ffff, 6'h3f);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'd1,     6'd0);
		send_req(MODE_ADD,    16'haaaa, 16'hffff, 17'd0,     6'd0);
		send_req(MODE_ADD,    16'h5555, 16'h5555, 17'd0,     6'd0);
		send_req(MODE_FIND,   16'h0000, 16'h0000, 17'h05556, 6'd0);
		send_req(MODE_REMOVE, 16'h0000, 16'h0000, 17'd0,     6'd2);
		send_clear();

		// sender holds off until the table has answered everything
		hold_until_drained();

		random_target = items_sent + RANDOM_ITEMS;
		quiet_from    = random_target - QUIET_ITEMS;
		episode       = 0;
		while (items_sent < random_target) begin
			if (episode == 0 || $urandom_range(0, 5) == 0) begin
				// fill to the brim, then hit the full-table paths
				send_clear();
				while (tracker.used < DEPTH) add_random();
				s = 16'($urandom);
				send_req(MODE_ADD, s, s, 17'($urandom), 6'($urandom));
				send_req(MODE_FIND, 16'($urandom), 16'($urandom), 17'd1, 6'($urandom));
				repeat (12) begin
					case ($urandom_range(0, 3))
					0: add_random();
					1, 2: find_random();
					default: remove_random();
					endcase
				end
			end else begin
				if ($urandom_range(0, 2) == 0) send_clear();
				repeat ($urandom_range(15, 40)) begin
					case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6: add_random();
					7, 8, 9, 10, 11, 12, 13, 14: find_random();
					15, 16, 17: remove_random();
					// noise: any mode, any fields
					18: send_req(mode_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
						17'($urandom), 6'($urandom));
					default: begin
						if ($urandom_range(0, 3) == 0) send_clear();
						else add_random();
					end
					endcase
				end
			end
			episode++;
			if (episode == 4) hold_until_drained();
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.flag_mismatch($sformatf("%0d replies never came", tracker.pending()));
		if (tracker.errors == 0) begin
			$display("tb_first_fit_fragment_allocator: clean");
		end else begin
			$display("tb_first_fit_fragment_allocator: errors");
		end
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#4000000;
		$display("tb_first_fit_fragment_allocator: errors");
		$finish;
	end

endmodule

`default_nettype wire
